FILE: design/assert_macros.svh
// Assertion macros shared by the arithmetic encoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle check
`define AE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// antecedent now, consequent in the next cycle
`define AE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

FILE: design/arenc_pkg.sv
// Types and constants of the arithmetic encoder.
package arenc_pkg;
  localparam int FreqBits  = 16;
  localparam int PendBits  = 10;
  localparam int RangeW    = 33;
  localparam int ProdW     = RangeW + FreqBits;
  localparam int SumW      = RangeW + 2;
  localparam int GuardMax  = 64;
  localparam int GuardW    = 7;
  localparam int BitCntW   = 5;
  localparam int QDepth    = 2;

  typedef struct packed {
    logic                action;
    logic                invalid;
    logic [FreqBits-1:0] cum_high;
    logic [FreqBits-1:0] cum_low;
    logic [FreqBits-1:0] total;
  } item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MULH, S_SDH, S_WDH, S_MULL, S_SDL, S_WDL, S_CHK,
    S_REN, S_EB, S_EP, S_FIN1, S_FINP, S_FIN2, S_PAD, S_ERRW
  } state_t;
endpackage

FILE: design/arenc_front.sv
// Front end: accepts requests, flags invalid counts, queues them for the back end.
module arenc_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_action,
  input  logic [arenc_pkg::FreqBits-1:0] in_cum_high,
  input  logic [arenc_pkg::FreqBits-1:0] in_cum_low,
  input  logic [arenc_pkg::FreqBits-1:0] in_total,
  output logic                          q_valid,
  output arenc_pkg::item_t              q_item,
  input  logic                          q_pop
);
  arenc_pkg::item_t q_mem_r [arenc_pkg::QDepth];
  logic       wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  arenc_pkg::item_t new_item;
  logic push;

  always_comb begin
    new_item.action   = in_action;
    new_item.cum_high = in_cum_high;
    new_item.cum_low  = in_cum_low;
    new_item.total    = in_total;
    new_item.invalid  = (in_total == '0) || (in_cum_high > in_total) ||
                        (in_cum_low >= in_cum_high);
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = q_mem_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = q_pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem_r[wptr_r] <= new_item;
  end
endmodule

FILE: design/arenc_div.sv
// Restoring divider, one quotient bit per cycle.
module arenc_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [arenc_pkg::ProdW-1:0]    dividend,
  input  logic [arenc_pkg::FreqBits-1:0] divisor,
  output logic [arenc_pkg::RangeW-1:0]   quotient,
  output arenc_pkg::div_stat_t           stat
);
  logic [arenc_pkg::ProdW-1:0]    dq_r, dq_nxt;
  logic [arenc_pkg::FreqBits-1:0] rem_r, rem_nxt, dvs_r;
  logic [arenc_pkg::FreqBits:0]   rem_sh;
  logic [5:0]                     cnt_r, cnt_nxt;
  logic                           busy_r, busy_nxt, done_r, done_nxt, ge;

  always_comb begin
    rem_sh   = {rem_r, dq_r[arenc_pkg::ProdW-1]};
    ge       = rem_sh >= {1'b0, dvs_r};
    rem_nxt  = rem_r;
    dq_nxt   = dq_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      dq_nxt   = dividend;
      cnt_nxt  = 6'(arenc_pkg::ProdW - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? arenc_pkg::FreqBits'(rem_sh - {1'b0, dvs_r})
                   : rem_sh[arenc_pkg::FreqBits-1:0];
      dq_nxt  = {dq_r[arenc_pkg::ProdW-2:0], ge};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
    cnt_r <= cnt_nxt;
    if (start) dvs_r <= divisor;
  end

  assign quotient  = dq_r[arenc_pkg::RangeW-1:0];
  assign stat.busy = busy_r;
  assign stat.done = done_r;
endmodule

FILE: design/arenc_back.sv
// Back end: interval narrowing, renormalization, bit packing, flush and error words.
`include "assert_macros.svh"
module arenc_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  arenc_pkg::item_t q_item,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [31:0]      out_code_word,
  output logic             out_last,
  output logic             out_error
);
  arenc_pkg::state_t state_r, state_nxt;
  logic [31:0] low_r, low_nxt, high_r, high_nxt, word_r, word_nxt;
  logic [arenc_pkg::PendBits-1:0] pend_r, pend_nxt;
  logic [arenc_pkg::BitCntW-1:0]  bits_r, bits_nxt;
  logic [arenc_pkg::GuardW-1:0]   guard_r, guard_nxt;
  logic sticky_r, sticky_nxt, bit_r, bit_nxt;
  logic [arenc_pkg::FreqBits-1:0] ch_r, cl_r, t_r;
  logic [arenc_pkg::ProdW-1:0]    prod_r, prod_nxt;
  logic [arenc_pkg::RangeW-1:0]   qh_r, qh_nxt, quo, range;
  logic [arenc_pkg::SumW-1:0]     hs, ls;
  arenc_pkg::div_stat_t dstat;
  logic div_start, latch;
  logic put, pbit, full, stall, out_busy;
  logic emit, emit_err, emit_last;
  logic ov_r, ov_nxt, ol_r, ol_nxt, oe_r, oe_nxt;
  logic [31:0] ow_r, ow_nxt;

  arenc_div u_div (
    .clk, .rst_n, .start(div_start), .dividend(prod_r), .divisor(t_r),
    .quotient(quo), .stat(dstat)
  );

  assign range    = {1'b0, high_r} - {1'b0, low_r} + 33'd1;
  assign hs       = {3'b0, low_r} + {2'b0, qh_r} - 35'd1;
  assign ls       = {3'b0, low_r} + {2'b0, quo};
  assign out_busy = ov_r && !out_ready;
  assign full     = (bits_r == '1);
  assign stall    = (put && full && out_busy) || (emit_err && out_busy);

  always_comb begin
    state_nxt  = state_r;
    low_nxt    = low_r;
    high_nxt   = high_r;
    pend_nxt   = pend_r;
    guard_nxt  = guard_r;
    sticky_nxt = sticky_r;
    bit_nxt    = bit_r;
    prod_nxt   = prod_r;
    qh_nxt     = qh_r;
    div_start  = 1'b0;
    q_pop      = 1'b0;
    latch      = 1'b0;
    put        = 1'b0;
    pbit       = 1'b0;
    emit_err   = 1'b0;
    emit_last  = 1'b0;
    unique case (state_r)
      arenc_pkg::S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          latch = 1'b1;
          if (q_item.action) begin
            if (pend_r == '1) sticky_nxt = 1'b1;
            else pend_nxt = pend_r + 1'b1;
            state_nxt = arenc_pkg::S_FIN1;
          end else if (q_item.invalid) begin
            state_nxt = arenc_pkg::S_ERRW;
          end else begin
            state_nxt = arenc_pkg::S_MULH;
          end
        end
      end
      arenc_pkg::S_MULH: begin
        prod_nxt  = range * ch_r;
        state_nxt = arenc_pkg::S_SDH;
      end
      arenc_pkg::S_SDH: begin
        div_start = 1'b1;
        state_nxt = arenc_pkg::S_WDH;
      end
      arenc_pkg::S_WDH: begin
        if (dstat.done) begin
          qh_nxt    = quo;
          state_nxt = arenc_pkg::S_MULL;
        end
      end
      arenc_pkg::S_MULL: begin
        prod_nxt  = range * cl_r;
        state_nxt = arenc_pkg::S_SDL;
      end
      arenc_pkg::S_SDL: begin
        div_start = 1'b1;
        state_nxt = arenc_pkg::S_WDL;
      end
      arenc_pkg::S_WDL: begin
        if (dstat.done) state_nxt = arenc_pkg::S_CHK;
      end
      arenc_pkg::S_CHK: begin
        if (hs < ls || hs[arenc_pkg::SumW-1:32] != '0) begin
          state_nxt = arenc_pkg::S_ERRW;
        end else begin
          high_nxt  = hs[31:0];
          low_nxt   = ls[31:0];
          guard_nxt = '0;
          state_nxt = arenc_pkg::S_REN;
        end
      end
      arenc_pkg::S_REN: begin
        if (guard_r == arenc_pkg::GuardW'(arenc_pkg::GuardMax)) begin
          state_nxt = arenc_pkg::S_IDLE;
        end else if (high_r[31] == low_r[31]) begin
          bit_nxt   = high_r[31];
          state_nxt = arenc_pkg::S_EB;
        end else if (low_r[30] && !high_r[30]) begin
          if (pend_r == '1) sticky_nxt = 1'b1;
          else pend_nxt = pend_r + 1'b1;
          low_nxt   = {1'b0, low_r[29:0], 1'b0};
          high_nxt  = {1'b1, high_r[29:0], 1'b1};
          guard_nxt = guard_r + 1'b1;
        end else begin
          state_nxt = arenc_pkg::S_IDLE;
        end
      end
      arenc_pkg::S_EB: begin
        put       = 1'b1;
        pbit      = bit_r;
        state_nxt = arenc_pkg::S_EP;
      end
      arenc_pkg::S_EP: begin
        if (pend_r == '0) begin
          low_nxt   = {low_r[30:0], 1'b0};
          high_nxt  = {high_r[30:0], 1'b1};
          guard_nxt = guard_r + 1'b1;
          state_nxt = arenc_pkg::S_REN;
        end else begin
          put      = 1'b1;
          pbit     = ~bit_r;
          pend_nxt = pend_r - 1'b1;
        end
      end
      arenc_pkg::S_FIN1: begin
        put       = 1'b1;
        pbit      = ~low_r[31];
        state_nxt = arenc_pkg::S_FINP;
      end
      arenc_pkg::S_FINP: begin
        if (pend_r == '0) begin
          state_nxt = arenc_pkg::S_FIN2;
        end else begin
          put      = 1'b1;
          pbit     = low_r[31];
          pend_nxt = pend_r - 1'b1;
        end
      end
      arenc_pkg::S_FIN2, arenc_pkg::S_PAD: begin
        put       = 1'b1;
        pbit      = low_r[31];
        state_nxt = arenc_pkg::S_PAD;
        if (full) begin
          emit_last  = 1'b1;
          state_nxt  = arenc_pkg::S_IDLE;
          low_nxt    = '0;
          high_nxt   = '1;
          pend_nxt   = '0;
          sticky_nxt = 1'b0;
        end
      end
      arenc_pkg::S_ERRW: begin
        emit_err   = 1'b1;
        sticky_nxt = 1'b1;
        state_nxt  = arenc_pkg::S_IDLE;
      end
      default: state_nxt = arenc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    word_nxt = word_r;
    bits_nxt = bits_r;
    emit     = 1'b0;
    if (put) begin
      word_nxt = {word_r[30:0], pbit};
      bits_nxt = bits_r + 1'b1;
      if (full) begin
        emit     = 1'b1;
        word_nxt = '0;
      end
    end
    ov_nxt = ov_r && !out_ready;
    ow_nxt = ow_r;
    ol_nxt = ol_r;
    oe_nxt = oe_r;
    if (emit) begin
      ov_nxt = 1'b1;
      ow_nxt = {word_r[30:0], pbit};
      ol_nxt = emit_last;
      oe_nxt = sticky_r;
    end else if (emit_err) begin
      ov_nxt = 1'b1;
      ow_nxt = '0;
      ol_nxt = 1'b0;
      oe_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= arenc_pkg::S_IDLE;
      low_r    <= '0;
      high_r   <= '1;
      pend_r   <= '0;
      word_r   <= '0;
      bits_r   <= '0;
      sticky_r <= 1'b0;
      ov_r     <= 1'b0;
    end else if (stall) begin
      ov_r <= ov_r && !out_ready;
    end else begin
      state_r  <= state_nxt;
      low_r    <= low_nxt;
      high_r   <= high_nxt;
      pend_r   <= pend_nxt;
      word_r   <= word_nxt;
      bits_r   <= bits_nxt;
      sticky_r <= sticky_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      guard_r <= guard_nxt;
      bit_r   <= bit_nxt;
      prod_r  <= prod_nxt;
      qh_r    <= qh_nxt;
      ow_r    <= ow_nxt;
      ol_r    <= ol_nxt;
      oe_r    <= oe_nxt;
    end
    if (latch) begin
      ch_r <= q_item.cum_high;
      cl_r <= q_item.cum_low;
      t_r  <= q_item.total;
    end
  end

  assign out_valid     = ov_r;
  assign out_code_word = ow_r;
  assign out_last      = ol_r;
  assign out_error     = oe_r;

  `AE_ASSERT(a_interval_order, high_r >= low_r, "interval high fell below low")
  `AE_ASSERT(a_idle_div_quiet, (state_r != arenc_pkg::S_IDLE) || !dstat.busy, "divider busy in idle")
  `AE_ASSERT_NXT(a_err_word, (state_r == arenc_pkg::S_ERRW) && !stall, out_valid && out_error && (out_code_word == 32'd0), "error request gave no error word")
endmodule

FILE: design/arith_encoder_32bit.sv
// Top level of the 32-bit binary arithmetic encoder.
// An encode request passes through the back end in these steps: it is taken from
// the queue, the two products are formed and each is divided on one shared
// restoring divider (49 quotient steps each, plus start and completion), and the
// new interval is checked. Renormalization then makes straddle steps, emits each
// matching bit (then one bit per pending bit it releases) and ends when neither
// applies or the guard limit is reached. An invalid request goes straight to an
// error word; a finish request emits the flushed and padding bits. Requests
// wait in a two-entry queue; result words leave through an output register and
// stall the back end only when a word is ready while the previous one still waits.
module arith_encoder_32bit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_action,
  input  logic [arenc_pkg::FreqBits-1:0] in_cum_high,
  input  logic [arenc_pkg::FreqBits-1:0] in_cum_low,
  input  logic [arenc_pkg::FreqBits-1:0] in_total,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [31:0]                    out_code_word,
  output logic                           out_last,
  output logic                           out_error
);
  logic             q_valid, q_pop;
  arenc_pkg::item_t q_item;

  arenc_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_action, .in_cum_high, .in_cum_low,
    .in_total, .q_valid, .q_item, .q_pop
  );

  arenc_back u_back (
    .clk, .rst_n, .q_valid, .q_item, .q_pop, .out_valid, .out_ready,
    .out_code_word, .out_last, .out_error
  );
endmodule
